[hdl/cps_pkg.sv]
// Package for the capability reply scanner: phase codes, byte constants,
// pattern lookup functions and the shared state and result structs.
// No dependencies.
package cps_pkg;

    localparam int DataWidth = 8;
    localparam int TokenLen  = 12;
    localparam int MarkerLen = 5;
    localparam int TokenIdxW  = $clog2(TokenLen);
    localparam int MarkerIdxW = 3;

    localparam logic [DataWidth-1:0] CharCr  = 8'h0D;
    localparam logic [DataWidth-1:0] CharLf  = 8'h0A;
    localparam logic [DataWidth-1:0] CharDot = 8'h2E;
    localparam logic [DataWidth-1:0] CharP   = 8'h50;

    typedef enum logic [2:0] {
        PH_MESSAGE    = 3'd0,
        PH_PIPELINING = 3'd1,
        PH_CRLF       = 3'd2,
        PH_DONE       = 3'd3,
        PH_ERROR      = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [TokenIdxW-1:0]  token_index;
        logic [MarkerIdxW-1:0] marker_index;
        logic                  pipelining_flag;
    } scan_state_t;

    // Packed so that phase lands in the lowest bits of tdata.
    typedef struct packed {
        logic       failed;
        logic       finished;
        logic       pipelining_seen;
        logic [2:0] phase;
    } scan_result_t;

    // Byte at a position of "PIPELINING\r\n".
    function automatic logic [DataWidth-1:0] token_char(input logic [TokenIdxW-1:0] idx);
        logic [DataWidth-1:0] c;
        case (idx)
            4'd0:    c = 8'h50;
            4'd1:    c = 8'h49;
            4'd2:    c = 8'h50;
            4'd3:    c = 8'h45;
            4'd4:    c = 8'h4C;
            4'd5:    c = 8'h49;
            4'd6:    c = 8'h4E;
            4'd7:    c = 8'h49;
            4'd8:    c = 8'h4E;
            4'd9:    c = 8'h47;
            4'd10:   c = CharCr;
            4'd11:   c = CharLf;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Byte at a position of "\r\n.\r\n".
    function automatic logic [DataWidth-1:0] marker_char(input logic [MarkerIdxW-1:0] idx);
        logic [DataWidth-1:0] c;
        case (idx)
            3'd0:    c = CharCr;
            3'd1:    c = CharLf;
            3'd2:    c = CharDot;
            3'd3:    c = CharCr;
            3'd4:    c = CharLf;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[hdl/capability_reply_scanner_unit.sv]
// Top level of the capability reply scanner: scan state register, next-state
// logic and output register. Depends on cps_pkg, cps_next and cps_out_reg.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) carries one byte of a POP3
//   capability reply per item. For every byte taken the master channel
//   (m_tvalid/m_tready/m_tdata) delivers exactly one result item: the parse
//   phase after that byte, the sticky pipelining flag, and finished/failed.
//   The result of a byte is valid on m_tvalid in the cycle after the
//   byte is accepted. One byte is taken per cycle while no result stalls,
//   as the scan state register updates on every accepted byte; a new byte
//   is taken in the same cycle the previous result is taken.
//   Stall: while a result waits and m_tready is low, s_tready drops and the
//   scan state holds; no byte is lost and no result is repeated.
//   Reset (aresetn low, synchronous): phase returns to message, both match
//   indexes and the pipelining flag clear, the output register empties.
//   Done and error are absorbing: later bytes still yield results, with the
//   phase unchanged, until the next reset.
module capability_reply_scanner_unit
    import cps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DataWidth-1:0] s_tdata,   // [7:0] data_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata    // [2:0] phase, [3] pipelining_seen,
                                            // [4] finished, [5] failed, [7:6] zero
);

    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t step_result;
    scan_result_t out_result;
    logic         accept;
    logic         room;

    // Take a byte whenever the output register has room for its result.
    assign s_tready = room;
    assign accept   = s_tvalid && room;

    cps_next u_next (
        .cur_state  (state_reg),
        .data_byte  (s_tdata),
        .next_state (state_next),
        .result     (step_result)
    );

    // Advance the scan state only on an accepted item; hold it otherwise.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_MESSAGE, token_index: '0,
                           marker_index: '0, pipelining_flag: 1'b0};
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    cps_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .load_result (step_result),
        .room        (room),
        .out_valid   (m_tvalid),
        .out_result  (out_result),
        .out_ready   (m_tready)
    );

    assign m_tdata = {2'b00, out_result};

`ifndef NO_ASSERTIONS
    // Done is absorbing.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_DONE |=> state_reg.phase == PH_DONE)
        else $error("done phase left before reset");

    // Error is absorbing.
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_ERROR |=> state_reg.phase == PH_ERROR)
        else $error("error phase left before reset");

    // Pipelining flag never clears once set.
    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pipelining_flag |=> state_reg.pipelining_flag)
        else $error("pipelining flag cleared");

    // Scan state only moves when a byte is taken.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(state_reg))
        else $error("scan state changed without an accepted item");

    // A result waiting on a stalled master blocks new bytes.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("byte accepted while result is stalled");
`endif

endmodule

[hdl/cps_next.sv]
// Next-state and result logic of the capability reply scanner.
// Depends on cps_pkg.
module cps_next
    import cps_pkg::*;
(
    input  scan_state_t          cur_state,
    input  logic [DataWidth-1:0] data_byte,
    output scan_state_t          next_state,
    output scan_result_t         result
);

    logic token_hit;
    logic marker_hit;

    assign token_hit  = (cur_state.token_index < TokenIdxW'(TokenLen))
                     && (token_char(cur_state.token_index) == data_byte);
    assign marker_hit = (cur_state.marker_index < MarkerIdxW'(MarkerLen))
                     && (marker_char(cur_state.marker_index) == data_byte);

    always_comb begin
        next_state = cur_state;
        unique case (cur_state.phase)
            PH_MESSAGE: begin
                priority if (data_byte == CharCr) begin
                    next_state.phase        = PH_CRLF;
                    next_state.marker_index = MarkerIdxW'(1);
                end else if (data_byte == CharP) begin
                    next_state.phase       = PH_PIPELINING;
                    next_state.token_index = TokenIdxW'(1);
                end else if (data_byte == CharDot) begin
                    // Dots in running text advance the marker index too.
                    if (cur_state.marker_index == MarkerIdxW'(2)) begin
                        next_state.phase        = PH_CRLF;
                        next_state.marker_index = MarkerIdxW'(3);
                    end else if (cur_state.marker_index != '1) begin
                        next_state.marker_index = cur_state.marker_index + 1'b1;
                    end
                end
            end
            PH_PIPELINING: begin
                priority if (!token_hit) begin
                    next_state.phase = PH_MESSAGE;
                end else if (cur_state.token_index == TokenIdxW'(TokenLen - 1)) begin
                    next_state.phase           = PH_CRLF;
                    next_state.pipelining_flag = 1'b1;
                    next_state.marker_index    = MarkerIdxW'(2);
                end else begin
                    next_state.token_index = cur_state.token_index + 1'b1;
                end
            end
            PH_CRLF: begin
                priority if (!marker_hit) begin
                    // A non-dot new line returns to text, or to the token on P.
                    if (cur_state.marker_index == MarkerIdxW'(2)) begin
                        if (data_byte == CharP) begin
                            next_state.phase       = PH_PIPELINING;
                            next_state.token_index = TokenIdxW'(1);
                        end else begin
                            next_state.phase = PH_MESSAGE;
                        end
                    end else begin
                        next_state.phase = PH_ERROR;
                    end
                end else if (cur_state.marker_index == MarkerIdxW'(MarkerLen - 1)) begin
                    next_state.phase = PH_DONE;
                end else begin
                    next_state.marker_index = cur_state.marker_index + 1'b1;
                end
            end
            default: begin
                // Done and error absorb every byte.
                next_state = cur_state;
            end
        endcase
    end

    always_comb begin
        result.phase           = next_state.phase;
        result.pipelining_seen = next_state.pipelining_flag;
        result.finished        = (next_state.phase == PH_DONE) || (next_state.phase == PH_ERROR);
        result.failed          = (next_state.phase == PH_ERROR);
    end

endmodule

[hdl/cps_out_reg.sv]
// Output register of the capability reply scanner: holds one result item
// for the master side and frees itself in the cycle the item is taken.
// Depends on cps_pkg.
module cps_out_reg
    import cps_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  scan_result_t load_result,
    output logic         room,
    output logic         out_valid,
    output scan_result_t out_result,
    input  logic         out_ready
);

    logic         valid_reg;
    logic         valid_next;
    scan_result_t result_reg;

    assign room       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
